// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for checker modules (clk, rst_n in scope).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FSTA_ASSERT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSTA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fsta_pkg.sv =====
// ----------------------------------------------------------------------------
// fsta_pkg
// Widths, codes and shared types of the fixed-step tick accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsta_pkg;

  localparam int TIME_W    = 63;
  localparam int PER_W     = 30;
  localparam int CAP_W     = 10;
  localparam int DROP_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int FRAC_W    = 16;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W     = 64;
  localparam int CNT_W     = 7;

  localparam logic [CNT_W-1:0] WHOLE_STEPS = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] FRAC_STEPS  = CNT_W'(FRAC_W);

  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(50000000);
  localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCH_UP = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_TAKE    = 2'd1,
    OP_REBASE  = 2'd2
  } fsta_op_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } fsta_div_cmd_t;

  typedef struct packed {
    logic done;
  } fsta_div_sts_t;

  typedef struct packed {
    logic [CAP_W-1:0]   ticks_granted;
    logic               tick_taken;
    logic               behind;
    logic [DROP_W-1:0]  dropped_ticks;
    logic [CAP_W-1:0]   pending_count;
    logic [TOTAL_W-1:0] total_ticks;
    logic [FRAC_W-1:0]  tick_fraction;
    logic [PER_W-1:0]   time_to_next;
  } fsta_res_t;

endpackage

`default_nettype wire

// ===== hdl/fsta_div.sv =====
// ----------------------------------------------------------------------------
// fsta_div
// Shared restoring divider, one quotient bit per cycle. The dividend shifts
// out of the top of the quotient register as quotient bits shift in below.
// ----------------------------------------------------------------------------
`default_nettype none

module fsta_div
  import fsta_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fsta_div_cmd_t       cmd,
  input  wire logic [DVD_W-1:0]    dvd,
  input  wire logic [PER_W-1:0]    dvs,
  input  wire logic [PER_W-1:0]    rem_init,
  output fsta_div_sts_t            sts,
  output logic [DVD_W-1:0]         quo,
  output logic [PER_W-1:0]         rem
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PER_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [PER_W-1:0] dvs_r, dvs_nxt;

  logic [PER_W:0]   shifted;
  logic [PER_W+1:0] diff;
  logic             fits;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = !diff[PER_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.steps;
      rem_nxt  = rem_init;
      quo_nxt  = dvd;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[PER_W-1:0] : shifted[PER_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done = done_r;
  assign quo      = quo_r;
  assign rem      = rem_r;

endmodule

`default_nettype wire

// ===== hdl/fsta_seq.sv =====
// ----------------------------------------------------------------------------
// fsta_seq
// Sequencer and tick state. Runs items through the shared divider: whole
// periods for an advance, then the Q0.16 fraction unless it saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module fsta_seq
  import fsta_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [TIME_W-1:0]   in_now_time,
  input  wire logic [PER_W-1:0]    per,
  input  wire logic [CAP_W-1:0]    cap,
  output fsta_div_cmd_t            div_cmd,
  output logic [DVD_W-1:0]         div_dvd,
  output logic [PER_W-1:0]         div_rem_init,
  input  wire fsta_div_sts_t       div_sts,
  input  wire logic [DVD_W-1:0]    div_quo,
  input  wire logic [PER_W-1:0]    div_rem,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output fsta_res_t                res
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_OPER  = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_WHOLE = 8'b0000_1000,
    ST_APPLY = 8'b0001_0000,
    ST_FCHK  = 8'b0010_0000,
    ST_FRAC  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } fsta_state_t;

  fsta_state_t        state_r, state_nxt;
  fsta_op_t           op_r, op_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  elap_r, elap_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [PER_W-1:0]   acc_r, acc_nxt;
  logic [CAP_W-1:0]   pend_r, pend_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               behind_r, behind_nxt;
  logic [DROP_W-1:0]  drop_r, drop_nxt;
  logic [CAP_W-1:0]   granted_r, granted_nxt;
  logic               taken_r, taken_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;

  logic [TIME_W:0]    tdiff;
  logic [CAP_W-1:0]   room;
  logic [CAP_W-1:0]   ticks;
  logic [DVD_W-1:0]   left;

  always_comb begin
    tdiff = {1'b0, now_r} - {1'b0, last_r};
    room  = (cap > pend_r) ? cap - pend_r : '0;
    ticks = (div_quo < DVD_W'(room)) ? div_quo[CAP_W-1:0] : room;
    left  = div_quo - DVD_W'(ticks);

    state_nxt   = state_r;
    op_nxt      = op_r;
    now_nxt     = now_r;
    elap_nxt    = elap_r;
    last_nxt    = last_r;
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    total_nxt   = total_r;
    behind_nxt  = behind_r;
    drop_nxt    = drop_r;
    granted_nxt = granted_r;
    taken_nxt   = taken_r;
    frac_nxt    = frac_r;

    div_cmd      = '0;
    div_dvd      = '0;
    div_rem_init = '0;

    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = fsta_op_t'(in_operation);
          now_nxt   = in_now_time;
          state_nxt = ST_OPER;
        end
      end
      ST_OPER: begin
        granted_nxt = '0;
        taken_nxt   = 1'b0;
        state_nxt   = ST_FCHK;
        case (op_r)
          OP_ADVANCE: begin
            last_nxt  = now_r;
            elap_nxt  = tdiff[TIME_W] ? '0 : tdiff[TIME_W-1:0];
            state_nxt = ST_SUM;
          end
          OP_TAKE: begin
            if (pend_r != '0) begin
              pend_nxt  = pend_r - CAP_W'(1);
              total_nxt = total_r + TOTAL_W'(1);
              taken_nxt = 1'b1;
            end
          end
          OP_REBASE: begin
            last_nxt   = now_r;
            acc_nxt    = '0;
            pend_nxt   = '0;
            drop_nxt   = '0;
            behind_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ST_SUM: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = WHOLE_STEPS;
        div_dvd       = DVD_W'(elap_r) + DVD_W'(acc_r);
        state_nxt     = ST_WHOLE;
      end
      ST_WHOLE: begin
        if (div_sts.done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        granted_nxt = ticks;
        pend_nxt    = pend_r + ticks;
        if (left != '0) begin
          behind_nxt = 1'b1;
          drop_nxt   = (left[DVD_W-1:DROP_W] != '0) ? '1 : left[DROP_W-1:0];
          acc_nxt    = '0;
        end else begin
          behind_nxt = 1'b0;
          drop_nxt   = '0;
          acc_nxt    = div_rem;
        end
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        if (acc_r >= per) begin
          frac_nxt  = '1;
          state_nxt = ST_DONE;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.steps = FRAC_STEPS;
          div_rem_init  = acc_r;
          state_nxt     = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (div_sts.done) begin
          frac_nxt  = div_quo[FRAC_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.ticks_granted = granted_r;
    res.tick_taken    = taken_r;
    res.behind        = behind_r;
    res.dropped_ticks = drop_r;
    res.pending_count = pend_r;
    res.total_ticks   = total_r;
    res.tick_fraction = frac_r;
    res.time_to_next  = ((pend_r != '0) || (acc_r >= per)) ? '0 : per - acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      last_r   <= '0;
      acc_r    <= '0;
      pend_r   <= '0;
      total_r  <= '0;
      behind_r <= 1'b0;
      drop_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      acc_r    <= acc_nxt;
      pend_r   <= pend_nxt;
      total_r  <= total_nxt;
      behind_r <= behind_nxt;
      drop_r   <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    now_r     <= now_nxt;
    elap_r    <= elap_nxt;
    granted_r <= granted_nxt;
    taken_r   <= taken_nxt;
    frac_r    <= frac_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/fixed_step_tick_accumulator.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_accumulator
// Fixed-timestep tick generator with capped catch-up and dropped backlog.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_operation, in_now_time
//   out      out  out_valid/out_ready  ticks, flags, counts, fraction, time
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Advance: the serial divider works out 64 quotient bits of whole periods,
// then 16 bits of fraction. Take, re-base and unused codes skip the whole-
// period division, and the fraction division is skipped whenever the
// fraction saturates. One item in flight; in_ready is high whenever the
// sequencer is idle, even while the previous result waits in the output
// register. Synchronous active-low reset; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_step_tick_accumulator
  import fsta_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [TIME_W-1:0]    in_now_time,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CAP_W-1:0]          out_ticks_granted,
  output logic                      out_tick_taken,
  output logic                      out_behind,
  output logic [DROP_W-1:0]         out_dropped_ticks,
  output logic [CAP_W-1:0]          out_pending_count,
  output logic [TOTAL_W-1:0]        out_total_ticks,
  output logic [FRAC_W-1:0]         out_tick_fraction,
  output logic [PER_W-1:0]          out_time_to_next,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PER_W-1:0]     cfg_data
);

  logic [PER_W-1:0] period_r, period_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [PER_W-1:0] per_eff;

  logic             out_valid_r, out_valid_nxt;
  fsta_res_t        out_res_r, out_res_nxt;

  fsta_div_cmd_t    div_cmd;
  fsta_div_sts_t    div_sts;
  logic [DVD_W-1:0] div_dvd;
  logic [PER_W-1:0] div_rem_init;
  logic [DVD_W-1:0] div_quo;
  logic [PER_W-1:0] div_rem;

  logic             res_valid;
  logic             res_ready;
  fsta_res_t        res;

  assign cfg_ready = 1'b1;
  assign per_eff   = (period_r == '0) ? PER_W'(1) : period_r;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    period_nxt = period_r;
    cap_nxt    = cap_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_PERIOD:  period_nxt = cfg_data;
        CFG_MAX_CATCH_UP: cap_nxt    = cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  fsta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dvd      (div_dvd),
    .dvs      (per_eff),
    .rem_init (div_rem_init),
    .sts      (div_sts),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  fsta_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_now_time  (in_now_time),
    .per          (per_eff),
    .cap          (cap_r),
    .div_cmd      (div_cmd),
    .div_dvd      (div_dvd),
    .div_rem_init (div_rem_init),
    .div_sts      (div_sts),
    .div_quo      (div_quo),
    .div_rem      (div_rem),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign out_valid         = out_valid_r;
  assign out_ticks_granted = out_res_r.ticks_granted;
  assign out_tick_taken    = out_res_r.tick_taken;
  assign out_behind        = out_res_r.behind;
  assign out_dropped_ticks = out_res_r.dropped_ticks;
  assign out_pending_count = out_res_r.pending_count;
  assign out_total_ticks   = out_res_r.total_ticks;
  assign out_tick_fraction = out_res_r.tick_fraction;
  assign out_time_to_next  = out_res_r.time_to_next;

endmodule

`default_nettype wire

// ===== hdl/fsta_checker.sv =====
// ----------------------------------------------------------------------------
// fsta_checker
// Port-level checks of the tick accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fsta_checker
  import fsta_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [CAP_W-1:0]   out_ticks_granted,
  input wire logic               out_tick_taken,
  input wire logic               out_behind,
  input wire logic [DROP_W-1:0]  out_dropped_ticks,
  input wire logic [CAP_W-1:0]   out_pending_count,
  input wire logic [PER_W-1:0]   out_time_to_next
);

  `FSTA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pending_count) && $stable(out_dropped_ticks), "result changed while stalled")
  `FSTA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `FSTA_ASSERT(a_take_no_grant, out_valid && out_tick_taken, out_ticks_granted == '0, "take also granted ticks")
  `FSTA_ASSERT(a_behind_drop, out_valid, out_behind == (out_dropped_ticks != '0), "behind and dropped disagree")
  `FSTA_ASSERT(a_pending_ttn, out_valid && (out_pending_count != '0), out_time_to_next == '0, "tick pending but time to next nonzero")

endmodule

bind fixed_step_tick_accumulator fsta_checker u_fsta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ticks_granted (out_ticks_granted),
  .out_tick_taken    (out_tick_taken),
  .out_behind        (out_behind),
  .out_dropped_ticks (out_dropped_ticks),
  .out_pending_count (out_pending_count),
  .out_time_to_next  (out_time_to_next)
);

`default_nettype wire
